[design/correlated_poisson_pixel_sampler_unit_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the correlated Poisson pixel sampler
// Clocked assertion shorthands shared by the checker.
// ---------------------------------------------------------------------------
`ifndef CORRELATED_POISSON_PIXEL_SAMPLER_UNIT_ASSERT_SVH
`define CORRELATED_POISSON_PIXEL_SAMPLER_UNIT_ASSERT_SVH

// Assertion that is switched off while reset is held.
`define CPPS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is also checked across reset.
`define CPPS_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/cpps_pkg.sv]
// ---------------------------------------------------------------------------
// cpps_pkg
// Types, constants and the exponential table of the pixel sampler.
// ---------------------------------------------------------------------------
package cpps_pkg;

  // Fixed-point formats.
  localparam int RATE_FRAC_BITS = 10;
  localparam int PROB_FRAC_BITS = 128;
  localparam int PROB_W         = PROB_FRAC_BITS + 32;
  localparam int EXP_STEPS      = 16;
  localparam int COMPONENTS     = 7;
  localparam int MAX_COUNT_DEF  = 255;
  localparam int SUM_W          = 10;

  // Hash constants.
  localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_C1 = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_C2 = 64'h94D049BB133111EB;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_SCALE   = 2'd2;
  localparam logic [1:0] ST_UNUSED  = 2'd3;

  // Register indexes.
  localparam logic [2:0] REG_BASE_SEED   = 3'd0;
  localparam logic [2:0] REG_SEED_STRIDE = 3'd1;
  localparam logic [2:0] REG_RATE_ALL    = 3'd2;
  localparam logic [2:0] REG_PAIR_RATES  = 3'd3;
  localparam logic [2:0] REG_MARG_RATES  = 3'd4;

  typedef struct packed {
    logic [47:0] pixel_coordinate;
    logic [16:0] scale_c;
    logic [16:0] scale_m;
    logic [16:0] scale_y;
  } in_req_t;

  typedef struct packed {
    logic [SUM_W-1:0] count_c;
    logic [SUM_W-1:0] count_m;
    logic [SUM_W-1:0] count_y;
    logic [1:0]       status;
    logic             count_capped;
  } out_res_t;

  typedef struct packed {
    logic done;
    logic capped;
  } lane_stat_t;

  typedef logic [EXP_STEPS-1:0][PROB_W-1:0] exp_tab_t;

  // Bit-serial long division, used only while the table is elaborated.
  function automatic logic [PROB_W-1:0] fx_div_small(input logic [PROB_W-1:0] x,
                                                     input logic [31:0] d);
    logic [PROB_W-1:0] q;
    logic [32:0]       r;
    q = '0;
    r = '0;
    for (int n = PROB_W - 1; n >= 0; n--) begin
      r = {r[31:0], x[n]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[n] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-2^j * 2^-F) for every rate bit j: series for the first, squares after.
  function automatic exp_tab_t build_exp_table();
    logic [PROB_W-1:0]   term;
    logic [PROB_W-1:0]   sum;
    logic [PROB_W-1:0]   one;
    logic [2*PROB_W-1:0] prod;
    exp_tab_t            t;
    term = '0;
    term[PROB_FRAC_BITS-RATE_FRAC_BITS] = 1'b1;
    sum = '0;
    one = '0;
    one[PROB_FRAC_BITS] = 1'b1;
    for (int k = 1; k <= 64; k++) begin
      if (term != '0) begin
        if ((k & 1) == 1) sum = sum + term;
        else sum = sum - term;
        term = fx_div_small(term, 32'((k + 1) << RATE_FRAC_BITS));
      end
    end
    t[0] = one - sum;
    for (int j = 1; j < EXP_STEPS; j++) begin
      prod = t[j-1] * t[j-1];
      t[j] = prod[PROB_FRAC_BITS +: PROB_W];
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TABLE = build_exp_table();

endpackage

[design/correlated_poisson_pixel_sampler_unit.sv]
// Sequence: set-up states P1, P2 and GO, the two hash multiplies, one table product
// per set bit of each component rate, then a multiply and a divide per drawn event.
// Throughput: one request at a time; the seven lanes each have their own
// 32x32 multiply and radix-16 divide.
// Reset: synchronous, active low; control and configuration registers return to their documented values.
// ---------------------------------------------------------------------------
// correlated_poisson_pixel_sampler_unit
// Forms seven component rates and seeds, runs seven lanes, merges the counts.
// ---------------------------------------------------------------------------
module correlated_poisson_pixel_sampler_unit #(
  parameter int MAX_COUNT = cpps_pkg::MAX_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cpps_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output cpps_pkg::out_res_t out_res,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [63:0]        cfg_wdata
);

  localparam int CW = $clog2(MAX_COUNT + 1);
  localparam int NC = cpps_pkg::COMPONENTS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_P1   = 3'd1;
  localparam logic [2:0] S_P2   = 3'd2;
  localparam logic [2:0] S_GO   = 3'd3;
  localparam logic [2:0] S_RUN  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  // Configuration registers.
  logic [63:0] base_seed_r, seed_stride_r;
  logic [15:0] rate_all_r;
  logic [47:0] pair_r, marg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_seed_r   <= 64'd0;
      seed_stride_r <= 64'd1;
      rate_all_r    <= 16'd1024;
      pair_r        <= 48'h0400_0400_0400;
      marg_r        <= 48'h4000_4000_4000;
    end else if (cfg_we) begin
      case (cfg_addr)
        cpps_pkg::REG_BASE_SEED:   base_seed_r   <= cfg_wdata;
        cpps_pkg::REG_SEED_STRIDE: seed_stride_r <= cfg_wdata;
        cpps_pkg::REG_RATE_ALL:    rate_all_r    <= cfg_wdata[15:0];
        cpps_pkg::REG_PAIR_RATES:  pair_r        <= cfg_wdata[47:0];
        cpps_pkg::REG_MARG_RATES:  marg_r        <= cfg_wdata[47:0];
        default: ;
      endcase
    end
  end

  // Profile check: every rate and the seed stride set, marginals above shared and pair rates.
  logic [15:0] pr0, pr1, pr2, mr0, mr1, mr2;
  logic        cfg_ok, scale_hi;
  assign pr0 = pair_r[15:0];
  assign pr1 = pair_r[31:16];
  assign pr2 = pair_r[47:32];
  assign mr0 = marg_r[15:0];
  assign mr1 = marg_r[31:16];
  assign mr2 = marg_r[47:32];
  assign cfg_ok = (seed_stride_r != 64'd0) && (rate_all_r != 16'd0)
    && (pr0 != 16'd0) && (pr1 != 16'd0) && (pr2 != 16'd0)
    && (mr0 != 16'd0) && (mr1 != 16'd0) && (mr2 != 16'd0)
    && (18'(mr0) > 18'(rate_all_r) + 18'(pr0) + 18'(pr1))
    && (18'(mr1) > 18'(rate_all_r) + 18'(pr0) + 18'(pr2))
    && (18'(mr2) > 18'(rate_all_r) + 18'(pr1) + 18'(pr2));

  logic [2:0]          state_r;
  cpps_pkg::in_req_t   in_r;
  logic [1:0]          status_r;
  logic                out_valid_r;
  cpps_pkg::out_res_t  out_res_r;

  assign scale_hi = (in_r.scale_c > 17'd65536) || (in_r.scale_m > 17'd65536)
                    || (in_r.scale_y > 17'd65536);

  // Scale minima and scaled products.
  logic [16:0] s_cm, s_cy, s_my, s_all;
  assign s_cm  = (in_r.scale_c < in_r.scale_m) ? in_r.scale_c : in_r.scale_m;
  assign s_cy  = (in_r.scale_c < in_r.scale_y) ? in_r.scale_c : in_r.scale_y;
  assign s_my  = (in_r.scale_m < in_r.scale_y) ? in_r.scale_m : in_r.scale_y;
  assign s_all = (s_cm < in_r.scale_y) ? s_cm : in_r.scale_y;

  logic [32:0] p_all, p_cm, p_cy, p_my, p_c, p_m, p_y;
  assign p_all = rate_all_r * s_all;
  assign p_cm  = pr0 * s_cm;
  assign p_cy  = pr1 * s_cy;
  assign p_my  = pr2 * s_my;
  assign p_c   = mr0 * in_r.scale_c;
  assign p_m   = mr1 * in_r.scale_m;
  assign p_y   = mr2 * in_r.scale_y;

  logic [15:0] r_all_r, r_cm_r, r_cy_r, r_my_r, r_c_r, r_m_r, r_y_r;
  logic [NC-1:0][15:0] rates_r;
  logic [NC-1:0][63:0] seeds_r;

  // Remainder rate, clamped at zero.
  function automatic logic [15:0] remainder(input logic [15:0] mg, input logic [15:0] a,
                                            input logic [15:0] p, input logic [15:0] q);
    logic [18:0] v;
    v = 19'(mg) - 19'(a) - 19'(p) - 19'(q);
    return (v[18] || v == 19'd0) ? 16'd0 : v[15:0];
  endfunction

  // Component index times stride by shift and add.
  function automatic logic [63:0] stride_mult(input logic [2:0] idx, input logic [63:0] s);
    logic [63:0] acc;
    acc = 64'd0;
    for (int b = 0; b < 3; b++) begin
      if (idx[b]) acc = acc + (s << b);
    end
    return acc;
  endfunction

  // Lanes.
  logic                            lane_start;
  logic [NC-1:0][CW-1:0]           lane_cnt;
  cpps_pkg::lane_stat_t [NC-1:0]   lane_st;
  logic [NC-1:0]                   lane_done, lane_cap;

  assign lane_start = (state_r == S_GO) && (status_r == cpps_pkg::ST_OK);

  for (genvar g = 0; g < NC; g++) begin : g_lane
    cpps_lane #(.MAX_COUNT(MAX_COUNT)) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .start (lane_start),
      .rate  (rates_r[g]),
      .seed  (seeds_r[g]),
      .count (lane_cnt[g]),
      .stat  (lane_st[g])
    );
    assign lane_done[g] = lane_st[g].done;
    assign lane_cap[g]  = lane_st[g].capped;
  end

  cpps_pkg::out_res_t merge_res;
  cpps_merge #(.MAX_COUNT(MAX_COUNT)) u_merge (
    .comp   (lane_cnt),
    .capped (lane_cap),
    .res    (merge_res)
  );

  logic out_free, fin_fire;
  assign out_free = !out_valid_r || !out_stall;
  assign fin_fire = (state_r == S_FIN) && out_free;

  // Request sequencing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (fin_fire) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            in_r    <= in_req;
            state_r <= S_P1;
          end
        end
        S_P1: begin
          r_all_r <= p_all[31:16];
          r_cm_r  <= p_cm[31:16];
          r_cy_r  <= p_cy[31:16];
          r_my_r  <= p_my[31:16];
          r_c_r   <= p_c[31:16];
          r_m_r   <= p_m[31:16];
          r_y_r   <= p_y[31:16];
          for (int i = 0; i < NC; i++) begin
            seeds_r[i] <= 64'(in_r.pixel_coordinate) + base_seed_r
                          + stride_mult(3'(i), seed_stride_r);
          end
          status_r <= !cfg_ok ? cpps_pkg::ST_INVALID
                    : scale_hi ? cpps_pkg::ST_SCALE : cpps_pkg::ST_OK;
          state_r  <= S_P2;
        end
        S_P2: begin
          rates_r[0] <= r_all_r;
          rates_r[1] <= r_cm_r;
          rates_r[2] <= r_cy_r;
          rates_r[3] <= r_my_r;
          rates_r[4] <= remainder(r_c_r, r_all_r, r_cm_r, r_cy_r);
          rates_r[5] <= remainder(r_m_r, r_all_r, r_cm_r, r_my_r);
          rates_r[6] <= remainder(r_y_r, r_all_r, r_cy_r, r_my_r);
          state_r    <= S_GO;
        end
        S_GO: begin
          state_r <= (status_r == cpps_pkg::ST_OK) ? S_RUN : S_FIN;
        end
        S_RUN: begin
          if (&lane_done) state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            if (status_r == cpps_pkg::ST_OK) begin
              out_res_r <= merge_res;
            end else begin
              out_res_r <= '{count_c: '0, count_m: '0, count_y: '0,
                             status: status_r, count_capped: 1'b0};
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

[design/cpps_lane.sv]
// ---------------------------------------------------------------------------
// cpps_lane
// One component: splitmix64 uniform, table exponential and inverse-CDF search.
// ---------------------------------------------------------------------------
module cpps_lane #(
  parameter int MAX_COUNT = cpps_pkg::MAX_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [15:0]                    rate,
  input  logic [63:0]                    seed,
  output logic [$clog2(MAX_COUNT+1)-1:0] count,
  output cpps_pkg::lane_stat_t           stat
);

  localparam int CW   = $clog2(MAX_COUNT + 1);
  localparam int PW   = cpps_pkg::PROB_W;
  localparam int PFB  = cpps_pkg::PROB_FRAC_BITS;
  localparam int RFB  = cpps_pkg::RATE_FRAC_BITS;
  localparam int NL   = PW / 32;
  localparam int LW   = $clog2(NL + 1);
  localparam int IW   = $clog2(NL);
  localparam int SW   = $clog2(2 * NL - 1);
  localparam int AW   = 2 * PW;
  localparam int DW   = ((PW - RFB + 3) / 4) * 4;
  localparam int DCYC = DW / 4;
  localparam int DCW  = $clog2(DCYC + 1);
  localparam int EW   = $clog2(cpps_pkg::EXP_STEPS);

  localparam logic [3:0] L_IDLE = 4'd0;
  localparam logic [3:0] L_H1   = 4'd1;
  localparam logic [3:0] L_H1W  = 4'd2;
  localparam logic [3:0] L_H2W  = 4'd3;
  localparam logic [3:0] L_EXP  = 4'd4;
  localparam logic [3:0] L_EXPW = 4'd5;
  localparam logic [3:0] L_CMP  = 4'd6;
  localparam logic [3:0] L_MULW = 4'd7;
  localparam logic [3:0] L_DIV  = 4'd8;
  localparam logic [3:0] L_ADD  = 4'd9;

  logic [3:0]     state_r;
  logic           done_r, capped_r;
  logic [15:0]    rate_r;
  logic [63:0]    v_r, u_r;
  logic [PW-1:0]  prob_r, cum_r;
  logic [CW-1:0]  order_r, rem_r;
  logic [EW-1:0]  bit_r;
  logic [DW-1:0]  dv_r;
  logic [DCW-1:0] dcnt_r;

  // Multiply-accumulate engine: one 32x32 product per cycle.
  logic [PW-1:0]  ma_r, mb_r;
  logic [LW-1:0]  mna_r, mnb_r;
  logic [IW-1:0]  i_r, j_r;
  logic           iss_r, ppv_r, pfirst_r;
  logic [63:0]    pp_r;
  logic [SW-1:0]  psh_r;
  logic [AW-1:0]  acc_r;
  logic [31:0]    mul_a, mul_b;
  logic [63:0]    mul_p;
  logic           mac_idle;

  assign mul_a    = ma_r[32*i_r +: 32];
  assign mul_b    = mb_r[32*j_r +: 32];
  assign mul_p    = mul_a * mul_b;
  assign mac_idle = !iss_r && !ppv_r;

  // Hash arithmetic around the two multiplies.
  logic [63:0] h_s, h_s1, acc_lo, h_s2, h_fin;
  assign h_s    = v_r + cpps_pkg::GOLDEN;
  assign h_s1   = h_s ^ (h_s >> 30);
  assign acc_lo = acc_r[63:0];
  assign h_s2   = acc_lo ^ (acc_lo >> 27);
  assign h_fin  = acc_lo ^ (acc_lo >> 31);

  logic [PW-1:0] u_full, prob_mul;
  logic [PW:0]   cum_sum;
  assign u_full   = PW'(u_r) << (PFB - 64);
  assign prob_mul = acc_r[PFB +: PW];
  assign cum_sum  = {1'b0, cum_r} + {1'b0, prob_r};

  // Divider: four quotient bits per cycle against the event order.
  logic [DW-1:0] dv_nxt;
  logic [CW-1:0] rem_nxt;
  always_comb begin
    logic [CW:0] t;
    dv_nxt  = dv_r;
    rem_nxt = rem_r;
    for (int k = 0; k < 4; k++) begin
      t      = {rem_nxt, dv_nxt[DW-1]};
      dv_nxt = {dv_nxt[DW-2:0], 1'b0};
      if (t >= {1'b0, order_r}) begin
        t         = t - {1'b0, order_r};
        dv_nxt[0] = 1'b1;
      end
      rem_nxt = t[CW-1:0];
    end
  end

  // Product pipeline and accumulator.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppv_r <= 1'b0;
    end else begin
      ppv_r <= iss_r;
    end
    pp_r     <= mul_p;
    psh_r    <= SW'(i_r) + SW'(j_r);
    pfirst_r <= (i_r == '0) && (j_r == '0);
    if (ppv_r) begin
      acc_r <= (pfirst_r ? '0 : acc_r) + (AW'(pp_r) << (32 * psh_r));
    end
  end

  // Sequencer of one draw.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= L_IDLE;
      done_r   <= 1'b0;
      iss_r    <= 1'b0;
      capped_r <= 1'b0;
    end else begin
      // Step the product indices while issuing.
      if (iss_r) begin
        if (j_r == IW'(mnb_r - 1'b1)) begin
          j_r <= '0;
          if (i_r == IW'(mna_r - 1'b1)) iss_r <= 1'b0;
          else i_r <= i_r + 1'b1;
        end else begin
          j_r <= j_r + 1'b1;
        end
      end
      case (state_r)
        L_IDLE: begin
          if (start) begin
            rate_r   <= rate;
            v_r      <= seed;
            done_r   <= 1'b0;
            capped_r <= 1'b0;
            order_r  <= '0;
            state_r  <= L_H1;
          end
        end
        L_H1: begin
          ma_r    <= PW'(h_s1);
          mb_r    <= PW'(cpps_pkg::MIX_C1);
          mna_r   <= LW'(2);
          mnb_r   <= LW'(2);
          i_r     <= '0;
          j_r     <= '0;
          iss_r   <= 1'b1;
          state_r <= L_H1W;
        end
        L_H1W: begin
          if (mac_idle) begin
            ma_r    <= PW'(h_s2);
            mb_r    <= PW'(cpps_pkg::MIX_C2);
            i_r     <= '0;
            j_r     <= '0;
            iss_r   <= 1'b1;
            state_r <= L_H2W;
          end
        end
        L_H2W: begin
          if (mac_idle) begin
            u_r     <= {h_fin[63:11], 1'b1, 10'b0};
            prob_r  <= PW'(1) << PFB;
            bit_r   <= '0;
            state_r <= L_EXP;
          end
        end
        L_EXP: begin
          // Multiply in the table entry of every set rate bit.
          if (rate_r[bit_r]) begin
            ma_r    <= prob_r;
            mb_r    <= cpps_pkg::EXP_TABLE[bit_r];
            mna_r   <= LW'(NL);
            mnb_r   <= LW'(NL);
            i_r     <= '0;
            j_r     <= '0;
            iss_r   <= 1'b1;
            state_r <= L_EXPW;
          end else if (bit_r == EW'(cpps_pkg::EXP_STEPS - 1)) begin
            cum_r   <= prob_r;
            state_r <= L_CMP;
          end else begin
            bit_r <= bit_r + 1'b1;
          end
        end
        L_EXPW: begin
          if (mac_idle) begin
            prob_r <= prob_mul;
            if (bit_r == EW'(cpps_pkg::EXP_STEPS - 1)) begin
              cum_r   <= prob_mul;
              state_r <= L_CMP;
            end else begin
              bit_r   <= bit_r + 1'b1;
              state_r <= L_EXP;
            end
          end
        end
        L_CMP: begin
          if (u_full > cum_r) begin
            if (order_r >= CW'(MAX_COUNT)) begin
              capped_r <= 1'b1;
              done_r   <= 1'b1;
              state_r  <= L_IDLE;
            end else begin
              order_r <= order_r + 1'b1;
              ma_r    <= prob_r;
              mb_r    <= PW'(rate_r);
              mna_r   <= LW'(NL);
              mnb_r   <= LW'(1);
              i_r     <= '0;
              j_r     <= '0;
              iss_r   <= 1'b1;
              state_r <= L_MULW;
            end
          end else begin
            done_r  <= 1'b1;
            state_r <= L_IDLE;
          end
        end
        L_MULW: begin
          if (mac_idle) begin
            dv_r    <= DW'(acc_r[PW-1:RFB]);
            rem_r   <= '0;
            dcnt_r  <= '0;
            state_r <= L_DIV;
          end
        end
        L_DIV: begin
          dv_r   <= dv_nxt;
          rem_r  <= rem_nxt;
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == DCW'(DCYC - 1)) begin
            prob_r  <= PW'(dv_nxt);
            state_r <= L_ADD;
          end
        end
        L_ADD: begin
          // Saturating cumulative sum.
          cum_r   <= cum_sum[PW] ? '1 : cum_sum[PW-1:0];
          state_r <= L_CMP;
        end
        default: state_r <= L_IDLE;
      endcase
    end
  end

  assign count       = order_r;
  assign stat.done   = done_r;
  assign stat.capped = capped_r;

endmodule

[design/cpps_merge.sv]
// ---------------------------------------------------------------------------
// cpps_merge
// Adds the four components of each channel and saturates the sums.
// ---------------------------------------------------------------------------
module cpps_merge #(
  parameter int MAX_COUNT = cpps_pkg::MAX_COUNT_DEF
) (
  input  logic [cpps_pkg::COMPONENTS-1:0][$clog2(MAX_COUNT+1)-1:0] comp,
  input  logic [cpps_pkg::COMPONENTS-1:0]                          capped,
  output cpps_pkg::out_res_t                                       res
);

  localparam int CW  = $clog2(MAX_COUNT + 1);
  localparam int TW  = CW + 2;
  localparam int SMW = cpps_pkg::SUM_W;
  localparam logic [TW-1:0] SUM_MAX = TW'((1 << SMW) - 1);

  logic [TW-1:0] s_c, s_m, s_y;

  // Channel sums: shared, two pairs, own remainder.
  assign s_c = TW'(comp[0]) + TW'(comp[1]) + TW'(comp[2]) + TW'(comp[4]);
  assign s_m = TW'(comp[0]) + TW'(comp[1]) + TW'(comp[3]) + TW'(comp[5]);
  assign s_y = TW'(comp[0]) + TW'(comp[2]) + TW'(comp[3]) + TW'(comp[6]);

  assign res.count_c      = (s_c > SUM_MAX) ? SMW'(SUM_MAX) : SMW'(s_c);
  assign res.count_m      = (s_m > SUM_MAX) ? SMW'(SUM_MAX) : SMW'(s_m);
  assign res.count_y      = (s_y > SUM_MAX) ? SMW'(SUM_MAX) : SMW'(s_y);
  assign res.status       = cpps_pkg::ST_OK;
  assign res.count_capped = (|capped) || (s_c > SUM_MAX) || (s_m > SUM_MAX)
                            || (s_y > SUM_MAX);

endmodule

[design/cpps_checker.sv]
// ---------------------------------------------------------------------------
// cpps_checker
// Port-level checks of the pixel sampler, bound to the top level.
// ---------------------------------------------------------------------------
`include "correlated_poisson_pixel_sampler_unit_assert.svh"

module cpps_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input cpps_pkg::out_res_t out_res
);

  // A result held back stays offered.
  `CPPS_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result dropped while stalled")

  // A failed status carries no counts.
  `CPPS_ASSERT(a_zero_on_fail, clk, rst_n, out_valid && (out_res.status != cpps_pkg::ST_OK) |-> (out_res.count_c == 0) && (out_res.count_m == 0) && (out_res.count_y == 0) && !out_res.count_capped, "counts set on failed status")

  // The unused status code never appears.
  `CPPS_ASSERT(a_status_code, clk, rst_n, out_valid |-> out_res.status != cpps_pkg::ST_UNUSED, "unused status code")

  // One request at a time: an accepted request blocks the next cycle.
  `CPPS_ASSERT(a_one_at_a_time, clk, rst_n, in_valid && !in_stall |=> in_stall, "second request taken while busy")

  // Nothing is offered straight after reset.
  `CPPS_ASSERT_RST(a_reset_quiet, clk, $past(!rst_n) |-> !out_valid, "result offered after reset")

endmodule

bind correlated_poisson_pixel_sampler_unit cpps_checker u_cpps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_res   (out_res)
);
